FILE: src/cwc_pkg.sv
// shared types and constants of the charged-context walk counter
package cwc_pkg;

    // field widths fixed by the item format
    localparam int RANK_FIELD_W = 10;
    localparam int COUNT_W      = 64;
    localparam int STATUS_W     = 2;
    localparam int WINDOW_W     = 7;
    localparam int KMER_W       = 4;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 7;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KMER_BITS     = 2'd1;

    // configuration reset values and limits
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 7'd8;
    localparam logic [WINDOW_W-1:0] WINDOW_MAX   = 7'd64;
    localparam logic [KMER_W-1:0]   KMER_RESET   = 4'd10;

    // action codes
    localparam logic ACTION_LOAD = 1'b0;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_LOAD_RANGE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_QUERY_RANGE = 2'd2;

    typedef logic [COUNT_W-1:0] count_t;

    // input beat
    typedef struct packed {
        logic                    action;
        logic [RANK_FIELD_W-1:0] rank_index;
        logic [RANK_FIELD_W-1:0] next_rank_zero;
        logic [RANK_FIELD_W-1:0] next_rank_one;
    } in_item_t;

    // result beat
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        count_t              prefix_count;
        count_t              suffix_count;
        count_t              total_count;
    } out_item_t;

endpackage

FILE: src/cwc_ram.sv
// generic single-write, single-read memory with registered read data
module cwc_ram
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds its data between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/charged_context_walk_counter_top.sv
// top level of the charged-context walk counter: tables, count memories and walk sequencer
//
// A load beat writes one entry of both successor tables when all its fields are in range
// and returns its status. A query beat for rank r with n = 2^k ranks in use and w walk
// steps runs a walk count on one shared 64-bit adder and two ping-pong count memories.
// Each walk step clears the next-count memory rank by rank, then for each visited rank
// latches its count and successors (RDA) and adds it into both successors of the
// next-count memory (WRA, WRB), a read-modify-write through its single read port.
// The block takes no new beat while a query runs; a finished result waits in the output
// register while the next beat is accepted.
module charged_context_walk_counter_top
    import cwc_pkg::*;
#(
    parameter int RANK_BITS = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int DEPTH = 1 << RANK_BITS;
    localparam int IDX_W = RANK_BITS + 1;
    localparam int CMP_W = (IDX_W > RANK_FIELD_W) ? IDX_W : RANK_FIELD_W;
    localparam logic [KMER_W:0] K_MAX = RANK_BITS[KMER_W:0];

    typedef logic [RANK_BITS-1:0] rank_t;
    typedef logic [IDX_W-1:0]     idx_t;

    // one port group of a count memory
    typedef struct packed {
        logic   we;
        rank_t  waddr;
        count_t wdata;
        logic   re;
        rank_t  raddr;
    } cnt_port_t;

    typedef enum logic [15:0] {
        ST_IDLE     = 16'h0001,
        ST_DECODE   = 16'h0002,
        ST_SEED_CLR = 16'h0004,
        ST_SEED_WA  = 16'h0008,
        ST_SEED_WB  = 16'h0010,
        ST_CLR      = 16'h0020,
        ST_FETCH    = 16'h0040,
        ST_RDA      = 16'h0080,
        ST_WRA      = 16'h0100,
        ST_WRB      = 16'h0200,
        ST_SUM_RD   = 16'h0400,
        ST_SUM_ACC  = 16'h0800,
        ST_SUF_SEED = 16'h1000,
        ST_FINAL_RD = 16'h2000,
        ST_FINAL    = 16'h4000,
        ST_OUT      = 16'h8000
    } state_t;

    state_t              state_reg, state_next;
    logic [WINDOW_W-1:0] window_reg;
    logic [KMER_W-1:0]   kmer_reg;
    logic                sel_reg, sel_next;
    logic                suffix_reg, suffix_next;
    idx_t                idx_reg, idx_next;
    logic [WINDOW_W-1:0] steps_reg, steps_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_data_reg, out_data_next;
    in_item_t            item_reg, item_next;
    rank_t               a_reg, a_next;
    rank_t               b_reg, b_next;
    count_t              c_reg, c_next;
    count_t              acc_reg, acc_next;
    count_t              suf_reg, suf_next;
    count_t              tot_reg, tot_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic [KMER_W:0]     k_eff;
    logic [WINDOW_W-1:0] w_eff;
    idx_t                n_val;
    idx_t                last_idx;
    idx_t                r_ext;
    rank_t               r_rank;
    idx_t                lo_val;
    idx_t                idx_inc;
    rank_t               idx_rank;
    logic                step_end;

    logic                succ_we, succ_re;
    rank_t               succ_waddr, succ_raddr;
    rank_t               s0_rd, s1_rd;
    cnt_port_t           cur_p, nxt_p, cnt0_p, cnt1_p;
    count_t              cnt0_rd, cnt1_rd, cur_rd, nxt_rd;
    count_t              add_a, add_b, add_sum;

    // true when a rank field lies below the number of ranks in use
    function automatic logic below_n(input logic [RANK_FIELD_W-1:0] v, input idx_t n);
        return CMP_W'(v) < CMP_W'(n);
    endfunction

    // effective k and w, saturated into range
    always_comb
    begin
        if (kmer_reg == '0)
        begin
            k_eff = {{KMER_W{1'b0}}, 1'b1};
        end
        else if ({1'b0, kmer_reg} > K_MAX)
        begin
            k_eff = K_MAX;
        end
        else
        begin
            k_eff = {1'b0, kmer_reg};
        end
        if (window_reg == '0)
        begin
            w_eff = {{(WINDOW_W-1){1'b0}}, 1'b1};
        end
        else if (window_reg > WINDOW_MAX)
        begin
            w_eff = WINDOW_MAX;
        end
        else
        begin
            w_eff = window_reg;
        end
    end

    // rank bounds of the running walk
    assign n_val    = idx_t'(1) << k_eff;
    assign last_idx = n_val - idx_t'(1);
    assign r_ext    = IDX_W'(item_reg.rank_index);
    assign r_rank   = RANK_BITS'(item_reg.rank_index);
    assign lo_val   = suffix_reg ? (r_ext + idx_t'(1)) : r_ext;
    assign idx_inc  = idx_reg + idx_t'(1);
    assign idx_rank = idx_reg[RANK_BITS-1:0];

    // successor tables
    cwc_ram #(.WIDTH(RANK_BITS), .DEPTH(DEPTH)) u_succ_zero (
        .clk   (clk),
        .we    (succ_we),
        .waddr (succ_waddr),
        .wdata (RANK_BITS'(item_reg.next_rank_zero)),
        .re    (succ_re),
        .raddr (succ_raddr),
        .rdata (s0_rd)
    );

    cwc_ram #(.WIDTH(RANK_BITS), .DEPTH(DEPTH)) u_succ_one (
        .clk   (clk),
        .we    (succ_we),
        .waddr (succ_waddr),
        .wdata (RANK_BITS'(item_reg.next_rank_one)),
        .re    (succ_re),
        .raddr (succ_raddr),
        .rdata (s1_rd)
    );

    // ping-pong count memories, roles swapped after every walk step
    assign cnt0_p = sel_reg ? nxt_p : cur_p;
    assign cnt1_p = sel_reg ? cur_p : nxt_p;
    assign cur_rd = sel_reg ? cnt1_rd : cnt0_rd;
    assign nxt_rd = sel_reg ? cnt0_rd : cnt1_rd;

    cwc_ram #(.WIDTH(COUNT_W), .DEPTH(DEPTH)) u_count_a (
        .clk   (clk),
        .we    (cnt0_p.we),
        .waddr (cnt0_p.waddr),
        .wdata (cnt0_p.wdata),
        .re    (cnt0_p.re),
        .raddr (cnt0_p.raddr),
        .rdata (cnt0_rd)
    );

    cwc_ram #(.WIDTH(COUNT_W), .DEPTH(DEPTH)) u_count_b (
        .clk   (clk),
        .we    (cnt1_p.we),
        .waddr (cnt1_p.waddr),
        .wdata (cnt1_p.wdata),
        .re    (cnt1_p.re),
        .raddr (cnt1_p.raddr),
        .rdata (cnt1_rd)
    );

    // shared 64-bit adder: successor update, prefix sum and final total
    always_comb
    begin
        if (state_reg == ST_WRA || state_reg == ST_WRB)
        begin
            add_a = nxt_rd;
        end
        else
        begin
            add_a = acc_reg;
        end
        if (state_reg == ST_WRA)
        begin
            add_b = (a_reg == b_reg) ? {c_reg[COUNT_W-2:0], 1'b0} : c_reg;
        end
        else if (state_reg == ST_WRB)
        begin
            add_b = c_reg;
        end
        else
        begin
            add_b = cur_rd;
        end
    end

    assign add_sum = add_a + add_b;

    // walk sequencer
    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        suffix_next    = suffix_reg;
        idx_next       = idx_reg;
        steps_next     = steps_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        item_next      = item_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        acc_next       = acc_reg;
        suf_next       = suf_reg;
        tot_next       = tot_reg;
        status_next    = status_reg;
        in_ready       = 1'b0;
        succ_we        = 1'b0;
        succ_re        = 1'b0;
        succ_waddr     = r_rank;
        succ_raddr     = r_rank;
        cur_p          = '0;
        nxt_p          = '0;
        step_end       = 1'b0;

        // result register drains independently of the sequencer
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                acc_next    = '0;
                suf_next    = '0;
                tot_next    = '0;
                status_next = STATUS_OK;
                if (item_reg.action == ACTION_LOAD)
                begin
                    if (below_n(item_reg.rank_index, n_val) &&
                        below_n(item_reg.next_rank_zero, n_val) &&
                        below_n(item_reg.next_rank_one, n_val))
                    begin
                        succ_we = 1'b1;
                    end
                    else
                    begin
                        status_next = STATUS_LOAD_RANGE;
                    end
                    state_next = ST_OUT;
                end
                else if (!below_n(item_reg.rank_index, n_val))
                begin
                    status_next = STATUS_QUERY_RANGE;
                    state_next  = ST_OUT;
                end
                else
                begin
                    succ_re     = 1'b1;
                    idx_next    = '0;
                    suffix_next = 1'b0;
                    state_next  = ST_SEED_CLR;
                end
            end
            ST_SEED_CLR:
            begin
                cur_p.we    = 1'b1;
                cur_p.waddr = idx_rank;
                idx_next    = idx_inc;
                if (idx_reg == last_idx)
                begin
                    state_next = ST_SEED_WA;
                end
            end
            ST_SEED_WA:
            begin
                cur_p.we    = ({1'b0, s0_rd} < n_val);
                cur_p.waddr = s0_rd;
                cur_p.wdata = count_t'(1);
                state_next  = ST_SEED_WB;
            end
            ST_SEED_WB:
            begin
                cur_p.we    = ({1'b0, s1_rd} < n_val);
                cur_p.waddr = s1_rd;
                cur_p.wdata = count_t'(1);
                steps_next  = w_eff - WINDOW_W'(1);
                idx_next    = '0;
                if (w_eff == WINDOW_W'(1))
                begin
                    state_next = ST_SUM_RD;
                end
                else
                begin
                    state_next = ST_CLR;
                end
            end
            ST_CLR:
            begin
                nxt_p.we    = 1'b1;
                nxt_p.waddr = idx_rank;
                if (idx_reg == last_idx)
                begin
                    idx_next   = lo_val;
                    state_next = ST_FETCH;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            ST_FETCH:
            begin
                if (idx_reg < n_val)
                begin
                    cur_p.re   = 1'b1;
                    cur_p.raddr = idx_rank;
                    succ_re    = 1'b1;
                    succ_raddr = idx_rank;
                    state_next = ST_RDA;
                end
                else
                begin
                    step_end = 1'b1;
                end
            end
            ST_RDA:
            begin
                a_next      = s0_rd;
                b_next      = s1_rd;
                c_next      = cur_rd;
                nxt_p.re    = 1'b1;
                nxt_p.raddr = s0_rd;
                state_next  = ST_WRA;
            end
            ST_WRA:
            begin
                nxt_p.we    = ({1'b0, a_reg} < n_val);
                nxt_p.waddr = a_reg;
                nxt_p.wdata = add_sum;
                nxt_p.re    = 1'b1;
                nxt_p.raddr = b_reg;
                idx_next    = idx_inc;
                // prefetch the following rank
                if (idx_inc < n_val)
                begin
                    cur_p.re    = 1'b1;
                    cur_p.raddr = idx_inc[RANK_BITS-1:0];
                    succ_re     = 1'b1;
                    succ_raddr  = idx_inc[RANK_BITS-1:0];
                end
                state_next = ST_WRB;
            end
            ST_WRB:
            begin
                nxt_p.we    = ({1'b0, b_reg} < n_val) && (a_reg != b_reg);
                nxt_p.waddr = b_reg;
                nxt_p.wdata = add_sum;
                if (idx_reg < n_val)
                begin
                    state_next = ST_RDA;
                end
                else
                begin
                    step_end = 1'b1;
                end
            end
            ST_SUM_RD:
            begin
                cur_p.re    = 1'b1;
                cur_p.raddr = r_rank;
                idx_next    = r_ext + idx_t'(1);
                state_next  = ST_SUM_ACC;
            end
            ST_SUM_ACC:
            begin
                acc_next = add_sum;
                if (idx_reg < n_val)
                begin
                    cur_p.re    = 1'b1;
                    cur_p.raddr = idx_rank;
                    idx_next    = idx_inc;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = ST_SUF_SEED;
                end
            end
            ST_SUF_SEED:
            begin
                cur_p.we    = 1'b1;
                cur_p.waddr = idx_rank;
                cur_p.wdata = (idx_reg > r_ext) ? count_t'(1) : '0;
                if (idx_reg == last_idx)
                begin
                    idx_next    = '0;
                    suffix_next = 1'b1;
                    steps_next  = w_eff;
                    state_next  = ST_CLR;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            ST_FINAL_RD:
            begin
                cur_p.re    = 1'b1;
                cur_p.raddr = r_rank;
                state_next  = ST_FINAL;
            end
            ST_FINAL:
            begin
                suf_next   = cur_rd;
                tot_next   = add_sum;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.status       = status_reg;
                    out_data_next.prefix_count = acc_reg;
                    out_data_next.suffix_count = suf_reg;
                    out_data_next.total_count  = tot_reg;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // end of one walk step: swap memories and pick the next phase
        if (step_end)
        begin
            sel_next   = ~sel_reg;
            steps_next = steps_reg - WINDOW_W'(1);
            if (steps_reg == WINDOW_W'(1))
            begin
                state_next = suffix_reg ? ST_FINAL_RD : ST_SUM_RD;
            end
            else
            begin
                idx_next   = '0;
                state_next = ST_CLR;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            window_reg    <= WINDOW_RESET;
            kmer_reg      <= KMER_RESET;
            sel_reg       <= 1'b0;
            suffix_reg    <= 1'b0;
            idx_reg       <= '0;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            suffix_reg    <= suffix_next;
            idx_reg       <= idx_next;
            steps_reg     <= steps_next;
            out_valid_reg <= out_valid_next;
            // configuration beat
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_WINDOW_LENGTH: window_reg <= cfg_data[WINDOW_W-1:0];
                    CFG_KMER_BITS:     kmer_reg   <= cfg_data[KMER_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        item_reg     <= item_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        acc_reg      <= acc_next;
        suf_reg      <= suf_next;
        tot_reg      <= tot_next;
        status_reg   <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

endmodule

FILE: src/cwc_checker.sv
// port-level checker of the charged-context walk counter and its bind
module cwc_checker
    import cwc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    logic [1:0] pend_reg, pend_next;

    // beats accepted but not yet answered
    always_comb
    begin
        pend_next = pend_reg;
        if ((in_valid && in_ready) && !(out_valid && out_ready))
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!(in_valid && in_ready) && (out_valid && out_ready))
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // total is the wrapped sum of both counts
    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.total_count ==
                      COUNT_W'(out_data.prefix_count + out_data.suffix_count))
        else $error("total count mismatch");

    // a rejected beat carries a known status and no counts
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != STATUS_OK |->
            (out_data.status == STATUS_LOAD_RANGE || out_data.status == STATUS_QUERY_RANGE) &&
            out_data.prefix_count == '0 && out_data.suffix_count == '0 &&
            out_data.total_count == '0)
        else $error("rejected beat with bad status or nonzero counts");

    // no result without an input beat behind it
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result beat with no pending input");

    // at most one result waiting plus one in flight
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> pend_reg != 2'd2)
        else $error("input accepted with two results outstanding");

endmodule

bind charged_context_walk_counter_top cwc_checker u_cwc_checker (.*);

FILE: tb/charged_context_walk_counter_top_tb.sv
// testbench of the charged-context walk counter: directed and random loads and queries
module charged_context_walk_counter_top_tb
    import cwc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANK_BITS   = 10;
    localparam int RANK_DEPTH  = 1 << RANK_BITS;
    localparam int QUIET_LIMIT = 100000;
    localparam int TAIL_CYCLES = 20;
    localparam logic ACTION_QUERY = ~ACTION_LOAD;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    in_item_t               in_data;
    logic                   out_valid;
    logic                   out_ready;
    out_item_t              out_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // mirror of the successor tables, count memories and registers
    logic [RANK_FIELD_W-1:0] succ_zero [RANK_DEPTH];
    logic [RANK_FIELD_W-1:0] succ_one [RANK_DEPTH];
    bit                      entry_loaded [RANK_DEPTH];
    count_t                  walk_now [RANK_DEPTH];
    count_t                  walk_next [RANK_DEPTH];
    logic [WINDOW_W-1:0]     window_reg;
    logic [KMER_W-1:0]       kmer_reg;

    out_item_t awaited_counts[$];
    int        mismatch_count = 0;
    int        in_idle_pct = 21;
    int        out_idle_pct = 21;
    int        hold_off_request = 0;

    charged_context_walk_counter_top #(
        .RANK_BITS (RANK_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // number of ranks in use, k saturated into 1..RANK_BITS
    function automatic int rank_limit();
        int k;
        k = kmer_reg;
        if (k < 1) k = 1;
        if (k > RANK_BITS) k = RANK_BITS;
        return 1 << k;
    endfunction

    // walk steps, w saturated into 1..64
    function automatic int walk_steps();
        int w;
        w = window_reg;
        if (w < 1) w = 1;
        if (w > WINDOW_MAX) w = WINDOW_MAX;
        return w;
    endfunction

    // lowest rank from which every entry up to the top is loaded
    function automatic int loaded_floor(input int n);
        int r;
        r = n;
        while (r > 0 && entry_loaded[r-1]) r--;
        return r;
    endfunction

    // one walk step: move counts out of ranks lo..n-1 into both successors
    function automatic void advance_walk(input int lo, input int n);
        for (int f = 0; f < RANK_DEPTH; f++) walk_next[f] = '0;
        for (int f = lo; f < n; f++)
        begin
            if (succ_zero[f] < n) walk_next[succ_zero[f]] += walk_now[f];
            if (succ_one[f] < n) walk_next[succ_one[f]] += walk_now[f];
        end
        for (int f = 0; f < RANK_DEPTH; f++) walk_now[f] = walk_next[f];
    endfunction

    // expected result of one beat; a load also updates the table mirror
    function automatic out_item_t walk_count_result(input in_item_t item);
        out_item_t res;
        int        n;
        int        steps;
        int        r;
        count_t    prefix_sum;
        n = rank_limit();
        steps = walk_steps();
        r = item.rank_index;
        res = '0;
        if (item.action == ACTION_LOAD)
        begin
            if (r >= n || item.next_rank_zero >= n || item.next_rank_one >= n)
                res.status = STATUS_LOAD_RANGE;
            else
            begin
                succ_zero[r] = item.next_rank_zero;
                succ_one[r] = item.next_rank_one;
                entry_loaded[r] = 1'b1;
                res.status = STATUS_OK;
            end
            return res;
        end
        if (r >= n)
        begin
            res.status = STATUS_QUERY_RANGE;
            return res;
        end
        // prefix walks: seed both successors once each
        for (int f = 0; f < RANK_DEPTH; f++) walk_now[f] = '0;
        if (succ_zero[r] < n) walk_now[succ_zero[r]] = 64'd1;
        if (succ_one[r] < n) walk_now[succ_one[r]] = 64'd1;
        for (int i = 1; i < steps; i++) advance_walk(r, n);
        prefix_sum = '0;
        for (int f = r; f < n; f++) prefix_sum += walk_now[f];
        // suffix walks: seed every rank above r, read what reaches r
        for (int f = 0; f < RANK_DEPTH; f++) walk_now[f] = (f > r && f < n) ? 64'd1 : 64'd0;
        for (int i = 0; i < steps; i++) advance_walk(r + 1, n);
        res.status = STATUS_OK;
        res.prefix_count = prefix_sum;
        res.suffix_count = walk_now[r];
        res.total_count = prefix_sum + walk_now[r];
        return res;
    endfunction

    function automatic in_item_t load_item(input int r, input int z, input int o);
        in_item_t item;
        item.action = ACTION_LOAD;
        item.rank_index = RANK_FIELD_W'(r);
        item.next_rank_zero = RANK_FIELD_W'(z);
        item.next_rank_one = RANK_FIELD_W'(o);
        return item;
    endfunction

    function automatic in_item_t query_item(input int r);
        in_item_t item;
        item.action = ACTION_QUERY;
        item.rank_index = RANK_FIELD_W'(r);
        item.next_rank_zero = RANK_FIELD_W'($urandom_range(RANK_DEPTH - 1));
        item.next_rank_one = RANK_FIELD_W'($urandom_range(RANK_DEPTH - 1));
        return item;
    endfunction

    // offer one beat, optionally after a gap, and record its expected result
    task automatic send_item(input in_item_t item);
        if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (!in_ready);
        awaited_counts.push_back(walk_count_result(item));
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (awaited_counts.size() != 0);
    endtask

    // write both registers while the block is idle
    task automatic write_config(input logic [CFG_DATA_W-1:0] window_value,
                                input logic [CFG_DATA_W-1:0] kmer_value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_WINDOW_LENGTH;
        cfg_data <= window_value;
        do @(posedge clk); while (!cfg_ready);
        window_reg = window_value[WINDOW_W-1:0];
        cfg_index <= CFG_KMER_BITS;
        cfg_data <= kmer_value;
        do @(posedge clk); while (!cfg_ready);
        kmer_reg = kmer_value[KMER_W-1:0];
        cfg_valid <= 1'b0;
    endtask

    // reset settings, top ranks of the full table
    task automatic test_default_window();
        send_item(load_item(1023, 1023, 1022));
        send_item(load_item(1022, 1023, 1023));
        send_item(load_item(0, 0, 1023));
        send_item(query_item(1023));
        send_item(query_item(1022));
    endtask

    // zero registers saturate, range rejects, equal successors, stale successor
    task automatic test_range_checks();
        write_config(7'd0, 7'd0);
        send_item(load_item(2, 0, 0));
        send_item(load_item(0, 2, 0));
        send_item(load_item(0, 0, 1023));
        send_item(load_item(1023, 1023, 1023));
        send_item(load_item(1, 1, 1));
        send_item(query_item(1));
        send_item(query_item(0));
        send_item(query_item(2));
        send_item(query_item(1023));
    endtask

    // window above the maximum, counts that wrap past 64 bits
    task automatic test_window_extremes();
        write_config(7'd127, 7'd2);
        send_item(load_item(0, 0, 1));
        send_item(load_item(1, 0, 1));
        send_item(load_item(2, 2, 2));
        send_item(load_item(3, 2, 3));
        for (int r = 0; r < 4; r++) send_item(query_item(r));
    endtask

    // k above the maximum acts as the full rank width
    task automatic test_wide_kmer();
        write_config(7'd1, 7'd15);
        send_item(query_item(1023));
        send_item(query_item(1022));
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        hold_off_request = 300;
        for (int i = 0; i < 12; i++)
            send_item(load_item($urandom_range(1023), $urandom_range(1023), $urandom_range(1023)));
        drain_results();
    endtask

    // random phases: fill the table, then mixed loads and queries
    task automatic test_random_walks();
        in_item_t item;
        int       n;
        int       floor_rank;
        int       window_choice;
        for (int phase = 0; phase < 5; phase++)
        begin
            window_choice = ($urandom_range(7) == 0) ? 64 : $urandom_range(12, 1);
            write_config(CFG_DATA_W'(window_choice), CFG_DATA_W'($urandom_range(4, 1)));
            in_idle_pct = (phase == 0) ? 0 : 21;
            out_idle_pct = (phase == 0) ? 0 : 21;
            n = rank_limit();
            for (int i = 0; i < 14; i++)
            begin
                floor_rank = loaded_floor(n);
                if (floor_rank < n && $urandom_range(99) < 45)
                begin
                    if ($urandom_range(11) == 0)
                        item = query_item($urandom_range(RANK_DEPTH - 1, n));
                    else
                        item = query_item($urandom_range(n - 1, floor_rank));
                end
                else
                begin
                    item = load_item((floor_rank > 0 && $urandom_range(1))
                                         ? floor_rank - 1 : $urandom_range(n - 1),
                                     $urandom_range(n - 1), $urandom_range(n - 1));
                    // occasional field beyond the ranks in use
                    if ($urandom_range(9) == 0)
                        case ($urandom_range(2))
                            0: item.rank_index =
                                   RANK_FIELD_W'($urandom_range(RANK_DEPTH - 1, n));
                            1: item.next_rank_zero =
                                   RANK_FIELD_W'($urandom_range(RANK_DEPTH - 1, n));
                            default: item.next_rank_one =
                                   RANK_FIELD_W'($urandom_range(RANK_DEPTH - 1, n));
                        endcase
                end
                send_item(item);
            end
            drain_results();
        end
        in_idle_pct = 21;
        out_idle_pct = 21;
    endtask

    // receiver: random stalls, plus a counted hold-off on request
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request != 0)
            begin
                hold_left = hold_off_request;
                hold_off_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    task automatic check_field(input string label, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    // compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_counts.size() == 0)
            begin
                $display("%0t: result with none expected, expected nothing actual %p",
                         $time, out_data);
                mismatch_count++;
            end
            else
            begin
                want = awaited_counts.pop_front();
                check_field("status", want.status, out_data.status);
                check_field("prefix_count", want.prefix_count, out_data.prefix_count);
                check_field("suffix_count", want.suffix_count, out_data.suffix_count);
                check_field("total_count", want.total_count, out_data.total_count);
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // reset, then the tests in turn
    initial
    begin
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_WINDOW_LENGTH;
        cfg_data <= '0;
        rst_n <= 1'b0;
        window_reg = WINDOW_RESET;
        kmer_reg = KMER_RESET;
        for (int i = 0; i < RANK_DEPTH; i++)
        begin
            succ_zero[i] = '0;
            succ_one[i] = '0;
            entry_loaded[i] = 1'b0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_default_window();
        test_range_checks();
        test_window_extremes();
        test_wide_kmer();
        test_backpressure();
        test_random_walks();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
